[rtl/core/lla_pkg.sv]
// ----------------------------------------------------------------------------
// lla_pkg: shared definitions for the life-like automaton grid
// Grid geometry, operation codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lla_pkg;

  // Grid is GRID_DIM x GRID_DIM cells; a row of cells is one memory word.
  localparam int GRID_DIM = 64;
  localparam int ADDR_W   = $clog2(GRID_DIM);

  // Widths of the item fields.
  localparam int COORD_W   = 6;
  localparam int OP_W      = 2;
  localparam int IN_DATA_W = 16;  // row, col, alive_in, boost_in, padded
  localparam int OUT_DATA_W = 8;  // cell_alive, padded

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } lla_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESP
  } lla_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              item_load;  // capture the incoming item
    logic              cell_wr;    // single-cell write of the held item
    logic              rd_en;      // issue a row read
    logic              rd_sweep;   // read address comes from the sweep row
    logic [ADDR_W-1:0] sweep_row;  // row addressed by the sweep
    logic              res_load;   // load the result register
  } lla_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;        // operation code of the held item
    logic            out_free;  // result register can take a new result
  } lla_status_t;

endpackage

[rtl/core/lla_ctrl.sv]
// ----------------------------------------------------------------------------
// lla_ctrl: operation sequencer
// Accepts one item at a time, runs the write, read or generation sweep, and
// hands the result to the datapath's output register.
// ----------------------------------------------------------------------------
module lla_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lla_pkg::lla_status_t status_i,
  output lla_pkg::lla_cmd_t    cmd_o
);
  import lla_pkg::*;

  lla_state_e        state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              cnt_last;

  assign cnt_last = (cnt_q == ADDR_W'(GRID_DIM - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cnt_d = '0;
        if (status_i.op == OP_STEP) begin
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    cmd_o.sweep_row = cnt_q;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.item_load = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.cell_wr = (status_i.op == OP_WRITE);
        cmd_o.rd_en   = (status_i.op == OP_READ);
      end
      ST_SWEEP: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sweep = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_RESP: begin
        cmd_o.res_load = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/lla_datapath.sv]
// ----------------------------------------------------------------------------
// lla_datapath: grid storage, row window and result register
// Holds the cell and boost rows in memories, applies the life rule to a
// three-row window during a sweep, and drives the result register.
// ----------------------------------------------------------------------------
module lla_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lla_pkg::lla_cmd_t        cmd_i,
  output lla_pkg::lla_status_t     status_o,
  input  logic [lla_pkg::OP_W-1:0] op_i,
  input  logic [lla_pkg::COORD_W-1:0] row_i,
  input  logic [lla_pkg::COORD_W-1:0] col_i,
  input  logic                     alive_i,
  input  logic                     boost_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic                     res_cell_o,
  output logic                     res_done_o
);
  import lla_pkg::*;

  localparam logic [GRID_DIM-1:0] ROW_ONE = GRID_DIM'(1);

  // Held item.
  logic [OP_W-1:0]    op_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic               alive_q, boost_q;

  // Row memories; a row that was never written since reset reads as zero.
  logic [GRID_DIM-1:0] cell_mem  [GRID_DIM];
  logic [GRID_DIM-1:0] boost_mem [GRID_DIM];
  logic [GRID_DIM-1:0] cell_vld_q, boost_vld_q;

  logic [GRID_DIM-1:0] rd_cell_q, rd_boost_q;
  logic                rd_cell_vld_q, rd_boost_vld_q;
  logic [GRID_DIM-1:0] rd_cell, rd_boost;

  // Sweep window.
  logic                sw_vld_q;
  logic [ADDR_W-1:0]   sw_row_q;
  logic [GRID_DIM-1:0] above_q, here_q, boost_here_q;
  logic [GRID_DIM-1:0] next_row;

  logic                on_grid;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic                wr_en;
  logic [GRID_DIM-1:0] wr_data, wr_mask, col_hot;
  logic                sweep_wr;

  logic                res_valid_q, res_cell_q, res_done_q;
  logic                res_cell_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q    <= op_i;
      row_q   <= row_i;
      col_q   <= col_i;
      alive_q <= alive_i;
      boost_q <= boost_i;
    end
  end

  assign on_grid = (int'(row_q) < GRID_DIM) && (int'(col_q) < GRID_DIM);
  assign col_hot = ROW_ONE << col_q;

  // Write port: single-cell writes use a bit mask unless the row is still
  // unwritten, in which case the whole row is written with zeros around it.
  assign sweep_wr = sw_vld_q && (sw_row_q >= ADDR_W'(2));
  assign wr_en    = sweep_wr || (cmd_i.cell_wr && on_grid);
  assign wr_addr  = sweep_wr ? (sw_row_q - 1'b1) : row_q[ADDR_W-1:0];
  assign wr_data  = sweep_wr ? next_row : (alive_q ? col_hot : '0);
  assign wr_mask  = (sweep_wr || !cell_vld_q[wr_addr]) ? '1 : col_hot;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int b = 0; b < GRID_DIM; b++) begin
        if (wr_mask[b]) begin
          cell_mem[wr_addr][b] <= wr_data[b];
        end
      end
    end
    if (cmd_i.cell_wr && on_grid) begin
      for (int b = 0; b < GRID_DIM; b++) begin
        if (!boost_vld_q[row_q[ADDR_W-1:0]] || col_hot[b]) begin
          boost_mem[row_q[ADDR_W-1:0]][b] <= boost_q & col_hot[b];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q  <= '0;
      boost_vld_q <= '0;
    end else begin
      if (wr_en) begin
        cell_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.cell_wr && on_grid) begin
        boost_vld_q[row_q[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  // Read port with registered data.
  assign rd_addr = cmd_i.rd_sweep ? cmd_i.sweep_row : row_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_cell_q      <= cell_mem[rd_addr];
      rd_boost_q     <= boost_mem[rd_addr];
      rd_cell_vld_q  <= cell_vld_q[rd_addr];
      rd_boost_vld_q <= boost_vld_q[rd_addr];
    end
  end

  assign rd_cell  = rd_cell_vld_q  ? rd_cell_q  : '0;
  assign rd_boost = rd_boost_vld_q ? rd_boost_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_vld_q <= 1'b0;
    end else begin
      sw_vld_q <= cmd_i.rd_en && cmd_i.rd_sweep;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_row_q <= cmd_i.sweep_row;
    if (sw_vld_q) begin
      above_q      <= here_q;
      here_q       <= rd_cell;
      boost_here_q <= rd_boost;
    end
  end

  // Life rule on the window: above_q, here_q and the freshly read row below.
  always_comb begin
    logic [3:0] n;
    logic [3:0] thr;
    next_row = here_q;
    for (int c = 1; c < GRID_DIM - 1; c++) begin
      n = 4'(above_q[c-1]) + 4'(above_q[c]) + 4'(above_q[c+1])
        + 4'(here_q[c-1]) + 4'(here_q[c+1])
        + 4'(rd_cell[c-1]) + 4'(rd_cell[c]) + 4'(rd_cell[c+1]);
      thr = boost_here_q[c] ? 4'd2 : 4'd3;
      if (here_q[c]) begin
        next_row[c] = (n == 4'd2) || (n == thr);
      end else begin
        next_row[c] = (n == thr);
      end
    end
  end

  // Result register.
  assign res_cell_d = (op_q == OP_READ) && on_grid && rd_cell[col_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_cell_q <= res_cell_d;
      res_done_q <= (op_q == OP_STEP);
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_cell_o        = res_cell_q;
  assign res_done_o        = res_done_q;
  assign status_o.op       = op_q;
  assign status_o.out_free = !res_valid_q || res_ready_i;

endmodule

[rtl/core/life_like_automaton_grid.sv]
// ----------------------------------------------------------------------------
// life_like_automaton_grid: 64 x 64 life-like cellular automaton
// Each input item writes a cell, reads a cell or advances the grid by one
// generation; each item yields exactly one result item.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one operation per item. tuser carries the
// operation code (write, read, generation step) and tdata the row, column,
// alive and boost bits. The master channel returns one result per item:
// tdata bit 0 is the cell value on a read (zero otherwise) and tuser bit 0
// is set when a generation step has completed.
// A write or a read is accepted, executed in the next cycle, and its result
// is then placed in the output register in the response step. A generation
// step sweeps the grid one row per cycle through the single read and write
// port of the row memory, then drains the row window and gives its result.
// Items are processed one at a time: a new item is accepted only when the
// previous one has placed its result in the output register, so the block
// can hold one finished result while it takes the next item. If the
// receiver stalls, the result is held and the block waits in its response
// step. Reset clears all cells and boost bits to zero at once, with no
// clearing pass; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module life_like_automaton_grid (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [5:0] row, [11:6] col, [12] alive_in, [13] boost_in, [15:14] zero
  input  logic [lla_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [1:0] op
  input  logic [lla_pkg::OP_W-1:0]          s_axis_tuser_i,
  // Result items.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] cell_alive, [7:1] zero
  output logic [lla_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [0] step_done
  output logic                              m_axis_tuser_o
);
  import lla_pkg::*;

  lla_cmd_t    cmd;
  lla_status_t status;
  logic        res_cell;

  // The controller sequences each operation; the datapath owns the grid.
  lla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lla_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .op_i        (s_axis_tuser_i),
    .row_i       (s_axis_tdata_i[COORD_W-1:0]),
    .col_i       (s_axis_tdata_i[2*COORD_W-1:COORD_W]),
    .alive_i     (s_axis_tdata_i[2*COORD_W]),
    .boost_i     (s_axis_tdata_i[2*COORD_W+1]),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_cell_o  (res_cell),
    .res_done_o  (m_axis_tuser_o)
  );

  // The cell value sits in the lowest bit; the rest of the byte is zero.
  assign m_axis_tdata_o = {{(OUT_DATA_W-1){1'b0}}, res_cell};

endmodule
